// File: hw/rtl/second_best_spanning_tree_top_assert.svh
// Assertion macros shared by the second-best spanning tree block.
`ifndef SECOND_BEST_SPANNING_TREE_TOP_ASSERT_SVH
`define SECOND_BEST_SPANNING_TREE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SBST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbst assertion failed");

// Next-cycle implication, disabled during reset.
`define SBST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbst assertion failed");

`endif

// File: hw/rtl/sbst_pkg.sv
package sbst_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;
    localparam int WEIGHT_BITS  = 24;

    localparam int VTX_W   = 11;
    localparam int EIDX_W  = $clog2(MAX_EDGES);
    localparam int ECNT_W  = EIDX_W + 1;
    localparam int HT_W    = 4;
    localparam int SUM_W   = 36;
    localparam int DIFF_W  = WEIGHT_BITS + 1;
    localparam int VMEM_DEPTH = MAX_VERTICES + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [VTX_W-1:0]       a;
        logic [VTX_W-1:0]       b;
        logic [WEIGHT_BITS-1:0] w;
        logic                   last;
        logic                   bad;
    } edge_item_t;

    typedef struct packed {
        logic [VTX_W-1:0]       a;
        logic [VTX_W-1:0]       b;
        logic                   bad;
    } edge_rec_t;

    typedef struct packed {
        logic [EIDX_W-1:0]      idx;
        logic [WEIGHT_BITS-1:0] w;
    } ord_rec_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CLR,
        S_SORT,
        M_START,
        M_LDP,
        M_LDP2,
        M_LDQ,
        M_LDQ2,
        M_SEL,
        K_POS,
        K_IDX,
        K_EDGE,
        R_A,
        R_A2,
        R_B,
        R_B2,
        K_HX,
        K_HX2,
        K_HY2,
        D_V,
        D_RD,
        D_CHK,
        A_POS,
        A_IDX,
        A_EDGE,
        P_U,
        P_U2,
        P_V2,
        S_RES,
        S_OUT
    } state_t;

endpackage

// File: hw/rtl/sbst_ram.sv
module sbst_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/sbst_front.sv
module sbst_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sbst_pkg::VTX_W-1:0]          end_a,
    input  logic [sbst_pkg::VTX_W-1:0]          end_b,
    input  logic [sbst_pkg::WEIGHT_BITS-1:0]    edge_weight,
    input  logic                                last_edge,
    output logic                                q_valid,
    output sbst_pkg::edge_item_t                q_item,
    input  logic                                q_pop
);

    localparam int AW = sbst_pkg::FIFO_AW;

    sbst_pkg::edge_item_t fifo_reg [sbst_pkg::FIFO_DEPTH];
    sbst_pkg::edge_item_t item_in;
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          push;
    logic          pop;

    // ends that can never be valid for any vertex count
    always_comb
    begin
        item_in.a    = end_a;
        item_in.b    = end_b;
        item_in.w    = edge_weight;
        item_in.last = last_edge;
        item_in.bad  = (end_a == '0) || (end_b == '0) || (end_a == end_b)
                    || (end_a > sbst_pkg::VTX_W'(sbst_pkg::MAX_VERTICES))
                    || (end_b > sbst_pkg::VTX_W'(sbst_pkg::MAX_VERTICES));
    end

    assign in_stall = (count_reg == (AW+1)'(sbst_pkg::FIFO_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = fifo_reg[rd_ptr_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: hw/rtl/sbst_back.sv
`include "second_best_spanning_tree_top_assert.svh"

module sbst_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [sbst_pkg::VTX_W-1:0]       num_vertices,
    input  logic                             q_valid,
    input  sbst_pkg::edge_item_t             q_item,
    output logic                             q_pop,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [sbst_pkg::SUM_W-1:0]       second_weight,
    output logic                             unique_tree,
    output logic                             no_alternative
);

    localparam int VW  = sbst_pkg::VTX_W;
    localparam int EW  = sbst_pkg::EIDX_W;
    localparam int CW  = sbst_pkg::ECNT_W;
    localparam int WB  = sbst_pkg::WEIGHT_BITS;
    localparam int HW  = sbst_pkg::HT_W;
    localparam int SW  = sbst_pkg::SUM_W;
    localparam int DW  = sbst_pkg::DIFF_W;
    localparam int REC_W = $bits(sbst_pkg::edge_rec_t);
    localparam int ORD_W = $bits(sbst_pkg::ord_rec_t);

    sbst_pkg::state_t state_reg, state_next;

    logic          phase_reg, phase_next;   // 0 tree build, 1 alternatives
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] n_reg, n_next;
    logic [CW-1:0] width_reg, width_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW-1:0] q_reg, q_next;
    logic [CW-1:0] k_reg, k_next;
    logic          src_reg, src_next;
    sbst_pkg::ord_rec_t hp_reg, hp_next;
    sbst_pkg::ord_rec_t hq_reg, hq_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [WB-1:0] w_reg, w_next;
    logic [VW-1:0] ea_reg, ea_next;
    logic [VW-1:0] eb_reg, eb_next;
    logic [VW-1:0] rx_reg, rx_next;
    logic [VW-1:0] ra_reg, ra_next;
    logic [VW-1:0] rb_reg, rb_next;
    logic [HW-1:0] hx_reg, hx_next;
    logic [VW-1:0] joined_reg, joined_next;
    logic          done_reg, done_next;
    logic [SW-1:0] total_reg, total_next;
    logic [DW-1:0] best_reg, best_next;
    logic          found_reg, found_next;
    logic [VW-1:0] vi_reg, vi_next;
    logic [HW-1:0] dcnt_reg, dcnt_next;
    logic [VW-1:0] u_reg, u_next;
    logic [VW-1:0] v_reg, v_next;
    logic [WB-1:0] m_reg, m_next;
    logic [VW-1:0] pu_reg, pu_next;
    logic [HW-1:0] du_reg, du_next;
    logic [WB-1:0] ju_reg, ju_next;
    logic [SW-1:0] ow_reg, ow_next;
    logic          ou_reg, ou_next;
    logic          on_reg, on_next;
    logic          out_valid_reg, out_valid_next;

    // memory ports
    logic               est_we;
    sbst_pkg::edge_rec_t est_wd, est_rd;
    logic               ord0_we, ord1_we;
    logic [EW-1:0]      ord_wa, ord_ra;
    sbst_pkg::ord_rec_t ord_wd, ord0_rd, ord1_rd, ord_rd;
    logic               tk_we, tk_wd, tk_rd;
    logic               par_we, ht_we, dep_we;
    logic [VW-1:0]      par_wa, par_wd, ht_wa, vaddr, par_rd;
    logic [HW-1:0]      ht_wd, ht_rd, dep_rd;
    logic [WB-1:0]      jw_rd;

    // shared conditions
    logic               last_pop;
    logic               e_ok;
    logic               par_hit;
    logic               m_pin, m_qin, m_takep;
    logic [CW:0]        lo_w, lo_2w;
    logic               pos_end;
    logic [DW-1:0]      diff;
    logic [WB-1:0]      m_u, m_uv, m_v;

    assign last_pop = q_valid && q_item.last;
    assign e_ok     = !est_rd.bad && (est_rd.a <= n_reg) && (est_rd.b <= n_reg);
    assign par_hit  = (par_rd == rx_reg);
    assign m_pin    = (p_reg < mid_reg);
    assign m_qin    = (q_reg < hi_reg);
    assign m_takep  = m_pin && (!m_qin || (hp_reg.w <= hq_reg.w));
    assign lo_w     = {1'b0, lo_reg} + {1'b0, width_reg};
    assign lo_2w    = {1'b0, lo_reg} + {width_reg, 1'b0};
    assign pos_end  = (pos_reg == cnt_reg);
    assign diff     = (w_reg >= m_reg) ? DW'(w_reg - m_reg) : '0;
    assign m_u      = (ju_reg > m_reg) ? ju_reg : m_reg;
    assign m_v      = (jw_rd > m_reg) ? jw_rd : m_reg;
    assign m_uv     = (jw_rd > m_u) ? jw_rd : m_u;
    assign ord_rd   = src_reg ? ord1_rd : ord0_rd;

    assign q_pop          = (state_reg == sbst_pkg::S_IDLE) && q_valid;
    assign out_valid      = out_valid_reg;
    assign second_weight  = ow_reg;
    assign unique_tree    = ou_reg;
    assign no_alternative = on_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sbst_pkg::S_IDLE:  if (last_pop) state_next = sbst_pkg::S_CLR;
            sbst_pkg::S_CLR:   if (vi_reg == n_reg) state_next = sbst_pkg::S_SORT;
            sbst_pkg::S_SORT:
            begin
                state_next = (width_reg < cnt_reg) ? sbst_pkg::M_START : sbst_pkg::K_POS;
            end
            sbst_pkg::M_START:
            begin
                state_next = (lo_reg >= cnt_reg) ? sbst_pkg::S_SORT : sbst_pkg::M_LDP;
            end
            sbst_pkg::M_LDP:   state_next = sbst_pkg::M_LDP2;
            sbst_pkg::M_LDP2:  state_next = m_qin ? sbst_pkg::M_LDQ : sbst_pkg::M_SEL;
            sbst_pkg::M_LDQ:   state_next = sbst_pkg::M_LDQ2;
            sbst_pkg::M_LDQ2:  state_next = sbst_pkg::M_SEL;
            sbst_pkg::M_SEL:
            begin
                if (!m_pin && !m_qin)
                begin
                    state_next = sbst_pkg::M_START;
                end
                else if (m_takep)
                begin
                    state_next = (p_reg + 1'b1 < mid_reg) ? sbst_pkg::M_LDP : sbst_pkg::M_SEL;
                end
                else
                begin
                    state_next = (q_reg + 1'b1 < hi_reg) ? sbst_pkg::M_LDQ : sbst_pkg::M_SEL;
                end
            end
            sbst_pkg::K_POS:   state_next = pos_end ? sbst_pkg::D_V : sbst_pkg::K_IDX;
            sbst_pkg::K_IDX:   state_next = sbst_pkg::K_EDGE;
            sbst_pkg::K_EDGE:
            begin
                state_next = (done_reg || !e_ok) ? sbst_pkg::K_POS : sbst_pkg::R_A;
            end
            sbst_pkg::R_A:     state_next = sbst_pkg::R_A2;
            sbst_pkg::R_A2:    state_next = par_hit ? sbst_pkg::R_B : sbst_pkg::R_A;
            sbst_pkg::R_B:     state_next = sbst_pkg::R_B2;
            sbst_pkg::R_B2:
            begin
                if (!par_hit)
                begin
                    state_next = sbst_pkg::R_B;
                end
                else if (!phase_reg)
                begin
                    state_next = (ra_reg == rx_reg) ? sbst_pkg::K_POS : sbst_pkg::K_HX;
                end
                else
                begin
                    state_next = (ra_reg != rx_reg) ? sbst_pkg::A_POS : sbst_pkg::P_U;
                end
            end
            sbst_pkg::K_HX:    state_next = sbst_pkg::K_HX2;
            sbst_pkg::K_HX2:   state_next = sbst_pkg::K_HY2;
            sbst_pkg::K_HY2:   state_next = sbst_pkg::K_POS;
            sbst_pkg::D_V:     state_next = (vi_reg > n_reg) ? sbst_pkg::A_POS : sbst_pkg::D_RD;
            sbst_pkg::D_RD:    state_next = sbst_pkg::D_CHK;
            sbst_pkg::D_CHK:   state_next = par_hit ? sbst_pkg::D_V : sbst_pkg::D_RD;
            sbst_pkg::A_POS:   state_next = pos_end ? sbst_pkg::S_RES : sbst_pkg::A_IDX;
            sbst_pkg::A_IDX:   state_next = sbst_pkg::A_EDGE;
            sbst_pkg::A_EDGE:
            begin
                state_next = (tk_rd || !e_ok) ? sbst_pkg::A_POS : sbst_pkg::R_A;
            end
            sbst_pkg::P_U:
            begin
                state_next = (u_reg == v_reg) ? sbst_pkg::A_POS : sbst_pkg::P_U2;
            end
            sbst_pkg::P_U2:    state_next = sbst_pkg::P_V2;
            sbst_pkg::P_V2:    state_next = sbst_pkg::P_U;
            sbst_pkg::S_RES:   state_next = sbst_pkg::S_OUT;
            sbst_pkg::S_OUT:   if (!out_stall) state_next = sbst_pkg::S_IDLE;
            default:           state_next = sbst_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        n_next      = n_reg;
        width_next  = width_reg;
        lo_next     = lo_reg;
        mid_next    = mid_reg;
        hi_next     = hi_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        k_next      = k_reg;
        src_next    = src_reg;
        hp_next     = hp_reg;
        hq_next     = hq_reg;
        pos_next    = pos_reg;
        w_next      = w_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        rx_next     = rx_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        hx_next     = hx_reg;
        joined_next = joined_reg;
        done_next   = done_reg;
        total_next  = total_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        vi_next     = vi_reg;
        dcnt_next   = dcnt_reg;
        u_next      = u_reg;
        v_next      = v_reg;
        m_next      = m_reg;
        pu_next     = pu_reg;
        du_next     = du_reg;
        ju_next     = ju_reg;
        ow_next     = ow_reg;
        ou_next     = ou_reg;
        on_next     = on_reg;
        out_valid_next = out_valid_reg;

        est_we  = 1'b0;
        est_wd.a   = q_item.a;
        est_wd.b   = q_item.b;
        est_wd.bad = q_item.bad;
        ord0_we = 1'b0;
        ord1_we = 1'b0;
        ord_wa  = k_reg[EW-1:0];
        ord_wd  = m_takep ? hp_reg : hq_reg;
        ord_ra  = pos_reg[EW-1:0];
        tk_we   = 1'b0;
        tk_wd   = 1'b0;
        par_we  = 1'b0;
        ht_we   = 1'b0;
        dep_we  = 1'b0;
        par_wa  = vi_reg;
        par_wd  = vi_reg;
        ht_wa   = vi_reg;
        ht_wd   = '0;
        vaddr   = rx_reg;

        case (state_reg)
            sbst_pkg::S_IDLE:
            begin
                if (q_valid)
                begin
                    if (cnt_reg < CW'(sbst_pkg::MAX_EDGES))
                    begin
                        est_we     = 1'b1;
                        ord0_we    = 1'b1;
                        ord_wa     = cnt_reg[EW-1:0];
                        ord_wd.idx = cnt_reg[EW-1:0];
                        ord_wd.w   = q_item.w;
                        cnt_next   = cnt_reg + 1'b1;
                    end
                    if (q_item.last)
                    begin
                        if (num_vertices == '0)
                        begin
                            n_next = VW'(1);
                        end
                        else if (num_vertices > VW'(sbst_pkg::MAX_VERTICES))
                        begin
                            n_next = VW'(sbst_pkg::MAX_VERTICES);
                        end
                        else
                        begin
                            n_next = num_vertices;
                        end
                        vi_next     = VW'(1);
                        total_next  = '0;
                        best_next   = '1;
                        found_next  = 1'b0;
                        joined_next = '0;
                        done_next   = 1'b0;
                        width_next  = CW'(1);
                        src_next    = 1'b0;
                    end
                end
            end
            sbst_pkg::S_CLR:
            begin
                par_we = 1'b1;
                ht_we  = 1'b1;
                vi_next = vi_reg + 1'b1;
            end
            sbst_pkg::S_SORT:
            begin
                lo_next    = '0;
                pos_next   = '0;
                phase_next = 1'b0;
            end
            sbst_pkg::M_START:
            begin
                if (lo_reg >= cnt_reg)
                begin
                    width_next = {width_reg[CW-2:0], 1'b0};
                    src_next   = !src_reg;
                end
                else
                begin
                    mid_next = (lo_w < {1'b0, cnt_reg}) ? lo_w[CW-1:0] : cnt_reg;
                    hi_next  = (lo_2w < {1'b0, cnt_reg}) ? lo_2w[CW-1:0] : cnt_reg;
                    p_next   = lo_reg;
                    q_next   = (lo_w < {1'b0, cnt_reg}) ? lo_w[CW-1:0] : cnt_reg;
                    k_next   = lo_reg;
                end
            end
            sbst_pkg::M_LDP:   ord_ra = p_reg[EW-1:0];
            sbst_pkg::M_LDP2:  hp_next = ord_rd;
            sbst_pkg::M_LDQ:   ord_ra = q_reg[EW-1:0];
            sbst_pkg::M_LDQ2:  hq_next = ord_rd;
            sbst_pkg::M_SEL:
            begin
                if (!m_pin && !m_qin)
                begin
                    lo_next = lo_2w[CW-1:0];
                end
                else
                begin
                    // write the merged element into the other bank
                    ord0_we = src_reg;
                    ord1_we = !src_reg;
                    k_next  = k_reg + 1'b1;
                    if (m_takep)
                    begin
                        p_next = p_reg + 1'b1;
                    end
                    else
                    begin
                        q_next = q_reg + 1'b1;
                    end
                end
            end
            sbst_pkg::K_POS:
            begin
                if (pos_end)
                begin
                    vi_next = VW'(1);
                end
            end
            sbst_pkg::K_IDX:   w_next = ord_rd.w;
            sbst_pkg::K_EDGE:
            begin
                ea_next = est_rd.a;
                eb_next = est_rd.b;
                rx_next = est_rd.a;
                if (done_reg || !e_ok)
                begin
                    tk_we    = 1'b1;
                    pos_next = pos_reg + 1'b1;
                end
            end
            sbst_pkg::R_A2:
            begin
                if (par_hit)
                begin
                    ra_next = rx_reg;
                    rx_next = eb_reg;
                end
                else
                begin
                    rx_next = par_rd;
                end
            end
            sbst_pkg::R_B2:
            begin
                if (!par_hit)
                begin
                    rx_next = par_rd;
                end
                else
                begin
                    rb_next = rx_reg;
                    if (!phase_reg)
                    begin
                        if (ra_reg == rx_reg)
                        begin
                            tk_we    = 1'b1;
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    else if (ra_reg != rx_reg)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    else
                    begin
                        u_next = ea_reg;
                        v_next = eb_reg;
                        m_next = '0;
                    end
                end
            end
            sbst_pkg::K_HX:    vaddr = ra_reg;
            sbst_pkg::K_HX2:
            begin
                hx_next = ht_rd;
                vaddr   = rb_reg;
            end
            sbst_pkg::K_HY2:
            begin
                par_we = 1'b1;
                ht_we  = 1'b1;
                tk_we  = 1'b1;
                tk_wd  = 1'b1;
                if (hx_reg < ht_rd)
                begin
                    par_wa = ra_reg;
                    par_wd = rb_reg;
                    ht_wa  = rb_reg;
                    ht_wd  = (hx_reg + 1'b1 > ht_rd) ? hx_reg + 1'b1 : ht_rd;
                end
                else
                begin
                    par_wa = rb_reg;
                    par_wd = ra_reg;
                    ht_wa  = ra_reg;
                    ht_wd  = (ht_rd + 1'b1 > hx_reg) ? ht_rd + 1'b1 : hx_reg;
                end
                total_next  = total_reg + SW'(w_reg);
                joined_next = joined_reg + 1'b1;
                if (joined_reg + 1'b1 == n_reg - 1'b1)
                begin
                    done_next = 1'b1;
                end
                pos_next = pos_reg + 1'b1;
            end
            sbst_pkg::D_V:
            begin
                rx_next    = vi_reg;
                dcnt_next  = '0;
                pos_next   = '0;
                phase_next = 1'b1;
            end
            sbst_pkg::D_CHK:
            begin
                if (par_hit)
                begin
                    dep_we  = 1'b1;
                    vi_next = vi_reg + 1'b1;
                end
                else
                begin
                    rx_next   = par_rd;
                    dcnt_next = dcnt_reg + 1'b1;
                end
            end
            sbst_pkg::A_IDX:   w_next = ord_rd.w;
            sbst_pkg::A_EDGE:
            begin
                ea_next = est_rd.a;
                eb_next = est_rd.b;
                rx_next = est_rd.a;
                if (tk_rd || !e_ok)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
            sbst_pkg::P_U:
            begin
                vaddr = u_reg;
                if (u_reg == v_reg)
                begin
                    found_next = 1'b1;
                    if (diff < best_reg)
                    begin
                        best_next = diff;
                    end
                    pos_next = pos_reg + 1'b1;
                end
            end
            sbst_pkg::P_U2:
            begin
                pu_next = par_rd;
                du_next = dep_rd;
                ju_next = jw_rd;
                vaddr   = v_reg;
            end
            sbst_pkg::P_V2:
            begin
                // climb the deeper side, or both when level
                if (du_reg > dep_rd)
                begin
                    m_next = m_u;
                    u_next = pu_reg;
                end
                else if (du_reg == dep_rd)
                begin
                    m_next = m_uv;
                    u_next = pu_reg;
                    v_next = par_rd;
                end
                else
                begin
                    m_next = m_v;
                    v_next = par_rd;
                end
            end
            sbst_pkg::S_RES:
            begin
                out_valid_next = 1'b1;
                if (found_reg)
                begin
                    ow_next = total_reg + SW'(best_reg);
                    ou_next = (best_reg == '0);
                    on_next = 1'b0;
                end
                else
                begin
                    ow_next = '0;
                    ou_next = 1'b0;
                    on_next = 1'b1;
                end
            end
            sbst_pkg::S_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    cnt_next       = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sbst_pkg::S_IDLE;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            n_reg         <= VW'(1);
            width_reg     <= CW'(1);
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            p_reg         <= '0;
            q_reg         <= '0;
            k_reg         <= '0;
            src_reg       <= 1'b0;
            hp_reg        <= '0;
            hq_reg        <= '0;
            pos_reg       <= '0;
            w_reg         <= '0;
            ea_reg        <= '0;
            eb_reg        <= '0;
            rx_reg        <= VW'(1);
            ra_reg        <= '0;
            rb_reg        <= '0;
            hx_reg        <= '0;
            joined_reg    <= '0;
            done_reg      <= 1'b0;
            total_reg     <= '0;
            best_reg      <= '1;
            found_reg     <= 1'b0;
            vi_reg        <= VW'(1);
            dcnt_reg      <= '0;
            u_reg         <= '0;
            v_reg         <= '0;
            m_reg         <= '0;
            pu_reg        <= '0;
            du_reg        <= '0;
            ju_reg        <= '0;
            ow_reg        <= '0;
            ou_reg        <= 1'b0;
            on_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            width_reg     <= width_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            p_reg         <= p_next;
            q_reg         <= q_next;
            k_reg         <= k_next;
            src_reg       <= src_next;
            hp_reg        <= hp_next;
            hq_reg        <= hq_next;
            pos_reg       <= pos_next;
            w_reg         <= w_next;
            ea_reg        <= ea_next;
            eb_reg        <= eb_next;
            rx_reg        <= rx_next;
            ra_reg        <= ra_next;
            rb_reg        <= rb_next;
            hx_reg        <= hx_next;
            joined_reg    <= joined_next;
            done_reg      <= done_next;
            total_reg     <= total_next;
            best_reg      <= best_next;
            found_reg     <= found_next;
            vi_reg        <= vi_next;
            dcnt_reg      <= dcnt_next;
            u_reg         <= u_next;
            v_reg         <= v_next;
            m_reg         <= m_next;
            pu_reg        <= pu_next;
            du_reg        <= du_next;
            ju_reg        <= ju_next;
            ow_reg        <= ow_next;
            ou_reg        <= ou_next;
            on_reg        <= on_next;
            out_valid_reg <= out_valid_next;
        end
    end

    sbst_ram #(.DEPTH(sbst_pkg::MAX_EDGES), .WIDTH(REC_W)) u_estore (
        .clk   (clk),
        .we    (est_we),
        .waddr (cnt_reg[EW-1:0]),
        .wdata (est_wd),
        .raddr (ord_rd.idx),
        .rdata (est_rd)
    );

    sbst_ram #(.DEPTH(sbst_pkg::MAX_EDGES), .WIDTH(ORD_W)) u_ord0 (
        .clk   (clk),
        .we    (ord0_we),
        .waddr (ord_wa),
        .wdata (ord_wd),
        .raddr (ord_ra),
        .rdata (ord0_rd)
    );

    sbst_ram #(.DEPTH(sbst_pkg::MAX_EDGES), .WIDTH(ORD_W)) u_ord1 (
        .clk   (clk),
        .we    (ord1_we),
        .waddr (ord_wa),
        .wdata (ord_wd),
        .raddr (ord_ra),
        .rdata (ord1_rd)
    );

    sbst_ram #(.DEPTH(sbst_pkg::MAX_EDGES), .WIDTH(1)) u_taken (
        .clk   (clk),
        .we    (tk_we),
        .waddr (pos_reg[EW-1:0]),
        .wdata (tk_wd),
        .raddr (pos_reg[EW-1:0]),
        .rdata (tk_rd)
    );

    sbst_ram #(.DEPTH(sbst_pkg::VMEM_DEPTH), .WIDTH(VW)) u_parent (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_wa),
        .wdata (par_wd),
        .raddr (vaddr),
        .rdata (par_rd)
    );

    sbst_ram #(.DEPTH(sbst_pkg::VMEM_DEPTH), .WIDTH(WB)) u_joinw (
        .clk   (clk),
        .we    (par_we && (state_reg == sbst_pkg::K_HY2)),
        .waddr (par_wa),
        .wdata (w_reg),
        .raddr (vaddr),
        .rdata (jw_rd)
    );

    sbst_ram #(.DEPTH(sbst_pkg::VMEM_DEPTH), .WIDTH(HW)) u_height (
        .clk   (clk),
        .we    (ht_we),
        .waddr (ht_wa),
        .wdata (ht_wd),
        .raddr (vaddr),
        .rdata (ht_rd)
    );

    sbst_ram #(.DEPTH(sbst_pkg::VMEM_DEPTH), .WIDTH(HW)) u_depth (
        .clk   (clk),
        .we    (dep_we),
        .waddr (vi_reg),
        .wdata (dcnt_reg),
        .raddr (vaddr),
        .rdata (dep_rd)
    );

    `SBST_ASSERT_IMP(a_out_in_state, clk, rst_n, out_valid_reg, state_reg == sbst_pkg::S_OUT)
    `SBST_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CW'(sbst_pkg::MAX_EDGES))
    `SBST_ASSERT_IMP(a_walk_vertex, clk, rst_n, (state_reg == sbst_pkg::R_A) || (state_reg == sbst_pkg::R_B), (rx_reg != '0) && (rx_reg <= n_reg))
    `SBST_ASSERT_NXT(a_last_starts, clk, rst_n, (state_reg == sbst_pkg::S_IDLE) && last_pop, state_reg == sbst_pkg::S_CLR)

endmodule

// File: hw/rtl/second_best_spanning_tree_top.sv
// Second-best minimum spanning tree engine. Edges enter one per cycle, while
// in_stall is low, through a four-entry item queue and are written into an
// on-chip edge memory (up to 4096 items; further ones are dropped). The item
// with last_edge set starts the computation, during which the queue fills and
// then stalls the input: the forest is reset, a bottom-up merge sort makes
// ceil(log2 E) passes between two ping-pong order banks, Kruskal then takes
// each edge in order with a root walk from each end, depths are found by
// walking each vertex up to its root, and each non-tree edge costs its root
// walks plus a level-by-level path search. Union by height keeps every walk
// within 10 levels. One result follows per graph and is held in an output
// register until taken; the edge memory is then free for the next graph.
module second_best_spanning_tree_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sbst_pkg::VTX_W-1:0]        end_a,
    input  logic [sbst_pkg::VTX_W-1:0]        end_b,
    input  logic [sbst_pkg::WEIGHT_BITS-1:0]  edge_weight,
    input  logic                              last_edge,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sbst_pkg::SUM_W-1:0]        second_weight,
    output logic                              unique_tree,
    output logic                              no_alternative,
    input  logic                              cfg_wr_en,
    input  logic [sbst_pkg::VTX_W-1:0]        cfg_wr_data
);

    logic [sbst_pkg::VTX_W-1:0] num_vertices_reg, num_vertices_next;
    logic                       q_valid;
    logic                       q_pop;
    sbst_pkg::edge_item_t       q_item;

    assign num_vertices_next = cfg_wr_en ? cfg_wr_data : num_vertices_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg <= sbst_pkg::VTX_W'(1);
        end
        else
        begin
            num_vertices_reg <= num_vertices_next;
        end
    end

    sbst_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .end_a       (end_a),
        .end_b       (end_b),
        .edge_weight (edge_weight),
        .last_edge   (last_edge),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    sbst_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .num_vertices   (num_vertices_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .second_weight  (second_weight),
        .unique_tree    (unique_tree),
        .no_alternative (no_alternative)
    );

endmodule

// File: verif/second_best_spanning_tree_top_test.sv
module second_best_spanning_tree_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000000;

    typedef struct packed {
        logic [sbst_pkg::VTX_W-1:0]       a;
        logic [sbst_pkg::VTX_W-1:0]       b;
        logic [sbst_pkg::WEIGHT_BITS-1:0] w;
        logic                             last;
    } edge_t;

    typedef struct packed {
        logic [sbst_pkg::SUM_W-1:0] sum;
        logic                       uniq;
        logic                       noalt;
    } answer_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [sbst_pkg::VTX_W-1:0]       end_a;
    logic [sbst_pkg::VTX_W-1:0]       end_b;
    logic [sbst_pkg::WEIGHT_BITS-1:0] edge_weight;
    logic                             last_edge;
    logic                             out_valid;
    logic                             out_stall;
    logic [sbst_pkg::SUM_W-1:0]       second_weight;
    logic                             unique_tree;
    logic                             no_alternative;
    logic                             cfg_wr_en;
    logic [sbst_pkg::VTX_W-1:0]       cfg_wr_data;

    second_best_spanning_tree_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .end_a(end_a), .end_b(end_b), .edge_weight(edge_weight), .last_edge(last_edge),
        .out_valid(out_valid), .out_stall(out_stall),
        .second_weight(second_weight), .unique_tree(unique_tree),
        .no_alternative(no_alternative),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    edge_t       pending_edges[$];
    answer_t     expected_answers[$];
    int          errors = 0;
    int          edges_sent = 0;
    bit          quiet = 0;
    bit          hold_send = 0;
    bit          took_in = 0;
    int          idle_cycles = 0;

    // shadow of the block's graph state
    logic [sbst_pkg::VTX_W-1:0]       ea[sbst_pkg::MAX_EDGES];
    logic [sbst_pkg::VTX_W-1:0]       eb[sbst_pkg::MAX_EDGES];
    logic [sbst_pkg::WEIGHT_BITS-1:0] ew[sbst_pkg::MAX_EDGES];
    int unsigned            loaded = 0;
    int unsigned            vertex_cfg = 1;
    int unsigned            up[sbst_pkg::MAX_VERTICES+1];
    int unsigned            jw[sbst_pkg::MAX_VERTICES+1];
    int unsigned            ht[sbst_pkg::MAX_VERTICES+1];
    int unsigned            dp[sbst_pkg::MAX_VERTICES+1];
    int unsigned            order[sbst_pkg::MAX_EDGES];
    bit                     taken[sbst_pkg::MAX_EDGES];

    function automatic int unsigned find_root(int unsigned v);
        while (up[v] != v)
            v = up[v];
        return v;
    endfunction

    function automatic bit usable(int unsigned i, int unsigned n);
        return ea[i] >= 1 && ea[i] <= n && eb[i] >= 1 && eb[i] <= n && ea[i] != eb[i];
    endfunction

    function automatic int unsigned heaviest_link(int unsigned u, int unsigned v);
        int unsigned m;
        m = 0;
        while (u != v) begin
            if (dp[u] > dp[v]) begin
                if (jw[u] > m) m = jw[u];
                u = up[u];
            end else if (dp[u] == dp[v]) begin
                if (jw[u] > m) m = jw[u];
                if (jw[v] > m) m = jw[v];
                u = up[u];
                v = up[v];
            end else begin
                if (jw[v] > m) m = jw[v];
                v = up[v];
            end
        end
        return m;
    endfunction

    // load one edge; on the last edge work out the second-best tree weight
    function automatic void absorb_edge(edge_t e);
        int unsigned      n, i, j, key, x, y, joined, d, m;
        bit               done, found;
        logic [sbst_pkg::SUM_W-1:0]  total;
        logic [sbst_pkg::DIFF_W-1:0] best, diff;
        answer_t          ans;
        if (loaded < sbst_pkg::MAX_EDGES) begin
            ea[loaded] = e.a;
            eb[loaded] = e.b;
            ew[loaded] = e.w;
            loaded++;
        end
        if (!e.last)
            return;
        n = vertex_cfg;
        if (n < 1) n = 1;
        if (n > sbst_pkg::MAX_VERTICES) n = sbst_pkg::MAX_VERTICES;
        for (i = 0; i <= sbst_pkg::MAX_VERTICES; i++) begin
            up[i] = i;
            jw[i] = 0;
            ht[i] = 0;
            dp[i] = 0;
        end
        total = '0;
        best = '1;
        // stable insertion sort by weight
        for (i = 0; i < loaded; i++)
            order[i] = i;
        for (i = 1; i < loaded; i++) begin
            key = order[i];
            j = i;
            while (j > 0 && ew[order[j-1]] > ew[key]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = key;
        end
        joined = 0;
        done = 0;
        for (i = 0; i < loaded; i++) begin
            taken[i] = 0;
            if (done || !usable(order[i], n))
                continue;
            x = find_root(ea[order[i]]);
            y = find_root(eb[order[i]]);
            if (x == y)
                continue;
            if (ht[x] < ht[y]) begin
                up[x] = y;
                jw[x] = ew[order[i]];
                if (ht[x] + 1 > ht[y]) ht[y] = ht[x] + 1;
            end else begin
                up[y] = x;
                jw[y] = ew[order[i]];
                if (ht[y] + 1 > ht[x]) ht[x] = ht[y] + 1;
            end
            taken[i] = 1;
            total = total + ew[order[i]];
            joined++;
            if (joined == n - 1)
                done = 1;
        end
        for (i = 1; i <= n; i++) begin
            d = 0;
            x = i;
            while (up[x] != x) begin
                d++;
                x = up[x];
            end
            dp[i] = d;
        end
        found = 0;
        for (i = 0; i < loaded; i++) begin
            key = order[i];
            if (taken[i] || !usable(key, n))
                continue;
            if (find_root(ea[key]) != find_root(eb[key]))
                continue;
            m = heaviest_link(ea[key], eb[key]);
            diff = (ew[key] >= m) ? sbst_pkg::DIFF_W'(ew[key] - m) : '0;
            found = 1;
            if (diff < best)
                best = diff;
        end
        if (found) begin
            ans.sum = total + best;
            ans.uniq = (best == 0);
            ans.noalt = 0;
        end else begin
            ans.sum = '0;
            ans.uniq = 0;
            ans.noalt = 1;
        end
        expected_answers = {expected_answers, ans};
        loaded = 0;
    endfunction

    function automatic bit roll_idle();
        return quiet ? 1'b0 : ($urandom_range(99) < 28);
    endfunction

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // sender and result-side stall, both changing on the falling edge
    always @(negedge clk) begin
        edge_t e;
        if (rst_n) begin
            if (!in_valid || took_in) begin
                if (pending_edges.size() > 0 && !hold_send && !roll_idle()) begin
                    e = pending_edges.pop_front();
                    in_valid <= 1'b1;
                    end_a <= e.a;
                    end_b <= e.b;
                    edge_weight <= e.w;
                    last_edge <= e.last;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= roll_idle();
        end
    end

    always @(posedge clk) begin
        answer_t got, want;
        if (rst_n) begin
            took_in <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                absorb_edge({end_a, end_b, edge_weight, last_edge});
            if (out_valid && !out_stall) begin
                got = {second_weight, unique_tree, no_alternative};
                if (expected_answers.size() == 0) begin
                    $display("%0t: unexpected result exp none act %h/%b/%b", $time,
                             got.sum, got.uniq, got.noalt);
                    errors++;
                end else begin
                    want = expected_answers.pop_front();
                    if (got.sum !== want.sum) begin
                        $display("%0t: second_weight exp %0d act %0d", $time, want.sum, got.sum);
                        errors++;
                    end
                    if (got.uniq !== want.uniq) begin
                        $display("%0t: unique_tree exp %b act %b", $time, want.uniq, got.uniq);
                        errors++;
                    end
                    if (got.noalt !== want.noalt) begin
                        $display("%0t: no_alternative exp %b act %b", $time, want.noalt,
                                 got.noalt);
                        errors++;
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("second_best_spanning_tree_top_test: FAIL");
                $finish;
            end
        end
    end

    task automatic push_edge(int unsigned a, int unsigned b, int unsigned w, bit last);
        edge_t e;
        e.a = sbst_pkg::VTX_W'(a);
        e.b = sbst_pkg::VTX_W'(b);
        e.w = sbst_pkg::WEIGHT_BITS'(w);
        e.last = last;
        pending_edges = {pending_edges, e};
        edges_sent++;
    endtask

    task automatic drain();
        do @(posedge clk);
        while (pending_edges.size() > 0 || in_valid || expected_answers.size() > 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_vertices(int unsigned v);
        drain();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= sbst_pkg::VTX_W'(v);
        vertex_cfg = v & 32'h7FF;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // random graph: mostly in-range edges, some noise endpoints, often tied weights
    task automatic random_graph(int unsigned m, bit noisy);
        int unsigned n, k, a, b, w, mode;
        n = vertex_cfg;
        if (n < 1) n = 1;
        if (n > sbst_pkg::MAX_VERTICES) n = sbst_pkg::MAX_VERTICES;
        mode = $urandom_range(2);
        for (k = 0; k < m; k++) begin
            if (noisy && $urandom_range(9) == 0) begin
                a = $urandom_range(2047);
                b = $urandom_range(2047);
            end else begin
                a = $urandom_range(n, 1);
                b = $urandom_range(n, 1);
            end
            case (mode)
                0: w = $urandom_range(7);
                1: w = $urandom_range(1000);
                default: w = $urandom;
            endcase
            push_edge(a, b, w & 24'hFFFFFF, k == m - 1);
        end
    endtask

    initial begin
        int unsigned sizes[10] = '{0, 2, 3, 4, 5, 8, 12, 20, 1024, 2047};
        int unsigned phase, g, k;
        rst_n = 0;
        in_valid = 0;
        end_a = '0;
        end_b = '0;
        edge_weight = '0;
        last_edge = 0;
        out_stall = 0;
        cfg_wr_en = 0;
        cfg_wr_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // reset vertex count of one: nothing can join
        push_edge(1, 1, 5, 1);
        push_edge(0, 2047, 24'hFFFFFF, 0);
        push_edge(1, 1, 0, 1);

        set_vertices(4);
        // equal-weight triangle: a zero-difference swap exists
        push_edge(1, 2, 3, 0);
        push_edge(2, 3, 3, 0);
        push_edge(3, 1, 3, 1);
        // cycle with a heavy chord, self-loop and out-of-range ends
        push_edge(1, 2, 1, 0);
        push_edge(2, 3, 2, 0);
        push_edge(3, 4, 3, 0);
        push_edge(4, 1, 10, 0);
        push_edge(1, 3, 24'hFFFFFF, 0);
        push_edge(2, 2, 4, 0);
        push_edge(5, 1, 1, 0);
        push_edge(0, 3, 2, 1);
        // two separate components
        push_edge(1, 2, 5, 0);
        push_edge(1, 2, 7, 0);
        push_edge(3, 4, 1, 1);
        // tree done early, later edges only alternatives
        push_edge(1, 2, 0, 0);
        push_edge(2, 3, 0, 0);
        push_edge(3, 4, 0, 0);
        push_edge(1, 4, 0, 0);
        push_edge(4, 2, 1, 1);

        set_vertices(0);
        push_edge(1, 2, 9, 1);
        set_vertices(2047);
        push_edge(1, 1024, 24'hFFFFFF, 0);
        push_edge(1024, 1, 0, 0);
        push_edge(1, 1024, 1, 1);

        phase = 0;
        while (edges_sent < 1480) begin
            if (phase % 4 == 3)
                set_vertices($urandom_range(1, 40));
            else
                set_vertices(sizes[$urandom_range(9)]);
            quiet = (phase == 5 || phase == 6);
            if (phase % 7 == 2)
                hold_send = 1;
            for (g = 0; g < 6; g++) begin
                k = $urandom_range(24, 1);
                random_graph(k, $urandom_range(3) == 0);
                if (hold_send && g == 2) begin
                    // release the backlog, then the sender waits until every result is back
                    hold_send = 0;
                    while (pending_edges.size() > 0 || in_valid)
                        @(posedge clk);
                    while (expected_answers.size() > 0)
                        @(posedge clk);
                end
            end
            hold_send = 0;
            phase++;
        end
        quiet = 0;
        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("second_best_spanning_tree_top_test: PASS");
        else
            $display("second_best_spanning_tree_top_test: FAIL");
        $finish;
    end

endmodule
